@@ src/etud_pkg.sv @@
// ----------------------------------------------------------------------------
// etud_pkg
// shared widths, reciprocal constants, payload types and the month table
// ----------------------------------------------------------------------------
package etud_pkg;

  // pipeline depth: day split, then the clock and date paths side by side
  localparam int SPLIT_STAGES = 2;
  localparam int PATH_STAGES  = 6;
  localparam int STAGES       = SPLIT_STAGES + PATH_STAGES;

  // field widths
  localparam int SECS_W = 32;
  localparam int DAYS_W = 16;
  localparam int REM_W  = 17;
  localparam int SEC_W  = 6;
  localparam int MIN_W  = 6;
  localparam int HOUR_W = 5;
  localparam int WDAY_W = 3;
  localparam int MDAY_W = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 12;
  localparam int DNUM_W = 20;
  localparam int YDAY_W = 9;

  localparam longint unsigned SECS_PER_DAY  = 86400;
  localparam longint unsigned SECS_PER_HOUR = 3600;
  localparam longint unsigned SECS_PER_MIN  = 60;
  localparam longint unsigned DAYS_PER_WEEK = 7;
  localparam longint unsigned EPOCH_WEEKDAY = 4;

  // days from 1 march of 1 bc to the epoch, less january and february
  localparam longint unsigned EPOCH_FROM_MARCH_1BC = 719527;
  localparam longint unsigned DAYS_JAN_FEB         = 59;
  localparam longint unsigned DAY_BASE = EPOCH_FROM_MARCH_1BC - DAYS_JAN_FEB;
  localparam longint unsigned MARCH_YDAY_OF_JAN    = 306;
  localparam longint unsigned GAUSS_MONTH_NUM      = 367;
  localparam longint unsigned YEAR_DAYS            = 365;
  localparam longint unsigned ERA_DAYS             = 146097;

  // seconds to days: (secs >> 7) / 675, exact for any 32-bit input
  localparam int DAY_PRE   = 7;
  localparam longint unsigned DAY_DIV = SECS_PER_DAY >> DAY_PRE;
  localparam int DAY_SHIFT = 35;
  localparam int DAY_MUL_W = 26;
  localparam logic [DAY_MUL_W-1:0] DAY_MUL =
    DAY_MUL_W'(((64'd1 << DAY_SHIFT) + DAY_DIV - 1) / DAY_DIV);

  // seconds of day to hours: (rem >> 4) / 225
  localparam int HOUR_PRE   = 4;
  localparam longint unsigned HOUR_DIV = SECS_PER_HOUR >> HOUR_PRE;
  localparam int HOUR_SHIFT = 21;
  localparam int HOUR_MUL_W = 14;
  localparam logic [HOUR_MUL_W-1:0] HOUR_MUL =
    HOUR_MUL_W'(((64'd1 << HOUR_SHIFT) + HOUR_DIV - 1) / HOUR_DIV);

  // seconds of hour to minutes: (rem >> 2) / 15
  localparam int MIN_PRE   = 2;
  localparam longint unsigned MIN_DIV = SECS_PER_MIN >> MIN_PRE;
  localparam int MIN_SHIFT = 14;
  localparam int MIN_MUL_W = 11;
  localparam logic [MIN_MUL_W-1:0] MIN_MUL =
    MIN_MUL_W'(((64'd1 << MIN_SHIFT) + MIN_DIV - 1) / MIN_DIV);

  // day number modulo seven
  localparam int WDAY_SHIFT = 19;
  localparam int WDAY_MUL_W = 17;
  localparam int WQ_W       = 13;
  localparam logic [WDAY_MUL_W-1:0] WDAY_MUL =
    WDAY_MUL_W'(((64'd1 << WDAY_SHIFT) + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK);

  // year estimate: (d + 2) * 400 / 146097 as one reciprocal multiply
  localparam int YEAR_SHIFT = 38;
  localparam int YEAR_MUL_W = 30;
  localparam logic [YEAR_MUL_W-1:0] YEAR_MUL =
    YEAR_MUL_W'(((64'd400 << YEAR_SHIFT) + ERA_DAYS - 1) / ERA_DAYS);

  // centuries: year / 100 = (year >> 2) / 25, year / 400 = (year >> 4) / 25
  localparam longint unsigned CENT_DIV = 25;
  localparam int CENT_SHIFT = 15;
  localparam int CENT_MUL_W = 11;
  localparam int Q100_W     = 6;
  localparam int Q400_W     = 4;
  localparam logic [CENT_MUL_W-1:0] CENT_MUL =
    CENT_MUL_W'(((64'd1 << CENT_SHIFT) + CENT_DIV - 1) / CENT_DIV);

  // march-based month: (yday + 31) * 10 / 306 = (yday + 31) * 5 / 153
  localparam int MON_SHIFT = 18;
  localparam int MON_MUL_W = 14;
  localparam logic [MON_MUL_W-1:0] MON_MUL =
    MON_MUL_W'(((64'd5 << MON_SHIFT) + 64'd152) / 64'd153);

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [REM_W-1:0]  rem;
  } etud_split_t;

  typedef struct packed {
    logic [SEC_W-1:0]  second_of_minute;
    logic [MIN_W-1:0]  minute_of_hour;
    logic [HOUR_W-1:0] hour_of_day;
    logic [WDAY_W-1:0] weekday;
  } etud_clock_t;

  typedef struct packed {
    logic [MDAY_W-1:0] day_of_month;
    logic [MON_W-1:0]  month_number;
    logic [YEAR_W-1:0] full_year;
  } etud_date_t;

  // first march-based day of year of a gauss month, 367 * mon / 12 - 30
  function automatic logic [YDAY_W-1:0] month_start(input logic [MON_W-1:0] mon);
    logic [YDAY_W-1:0] start;
    unique case (mon)
      4'd1:    start = YDAY_W'((GAUSS_MONTH_NUM * 1) / 12 - 30);
      4'd2:    start = YDAY_W'((GAUSS_MONTH_NUM * 2) / 12 - 30);
      4'd3:    start = YDAY_W'((GAUSS_MONTH_NUM * 3) / 12 - 30);
      4'd4:    start = YDAY_W'((GAUSS_MONTH_NUM * 4) / 12 - 30);
      4'd5:    start = YDAY_W'((GAUSS_MONTH_NUM * 5) / 12 - 30);
      4'd6:    start = YDAY_W'((GAUSS_MONTH_NUM * 6) / 12 - 30);
      4'd7:    start = YDAY_W'((GAUSS_MONTH_NUM * 7) / 12 - 30);
      4'd8:    start = YDAY_W'((GAUSS_MONTH_NUM * 8) / 12 - 30);
      4'd9:    start = YDAY_W'((GAUSS_MONTH_NUM * 9) / 12 - 30);
      4'd10:   start = YDAY_W'((GAUSS_MONTH_NUM * 10) / 12 - 30);
      4'd11:   start = YDAY_W'((GAUSS_MONTH_NUM * 11) / 12 - 30);
      4'd12:   start = YDAY_W'((GAUSS_MONTH_NUM * 12) / 12 - 30);
      default: start = '0;
    endcase
    return start;
  endfunction

endpackage

@@ src/etud_in_if.sv @@
// ----------------------------------------------------------------------------
// etud_in_if
// request channel carrying one epoch timestamp
// ----------------------------------------------------------------------------
interface etud_in_if;
  logic                         valid;
  logic                         ready;
  logic [etud_pkg::SECS_W-1:0]  epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

@@ src/etud_out_if.sv @@
// ----------------------------------------------------------------------------
// etud_out_if
// request channel carrying one utc calendar date and time of day
// ----------------------------------------------------------------------------
interface etud_out_if;
  logic                         valid;
  logic                         ready;
  logic [etud_pkg::SEC_W-1:0]   second_of_minute;
  logic [etud_pkg::MIN_W-1:0]   minute_of_hour;
  logic [etud_pkg::HOUR_W-1:0]  hour_of_day;
  logic [etud_pkg::MDAY_W-1:0]  day_of_month;
  logic [etud_pkg::MON_W-1:0]   month_number;
  logic [etud_pkg::YEAR_W-1:0]  full_year;
  logic [etud_pkg::WDAY_W-1:0]  weekday;

  modport source (
    output valid, output second_of_minute, output minute_of_hour, output hour_of_day,
    output day_of_month, output month_number, output full_year, output weekday,
    input ready
  );
  modport sink (
    input valid, input second_of_minute, input minute_of_hour, input hour_of_day,
    input day_of_month, input month_number, input full_year, input weekday,
    output ready
  );
endinterface

@@ src/etud_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// etud_pipe_ctrl
// valid bits and per-stage load enables of the elastic pipeline
// ----------------------------------------------------------------------------
module etud_pipe_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [etud_pkg::STAGES-1:0]   load
);

  logic [etud_pkg::STAGES-1:0] valid;
  logic [etud_pkg::STAGES-1:0] advance;

  // a stage may take new data when it is empty or its content moves on
  always_comb begin
    advance[etud_pkg::STAGES-1] = !valid[etud_pkg::STAGES-1] || out_ready;
    for (int k = etud_pkg::STAGES - 2; k >= 0; k--) begin
      advance[k] = !valid[k] || advance[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (advance[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < etud_pkg::STAGES; k++) begin
        if (advance[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign load      = advance;
  assign in_ready  = advance[0];
  assign out_valid = valid[etud_pkg::STAGES-1];

endmodule

@@ src/etud_day_split.sv @@
// ----------------------------------------------------------------------------
// etud_day_split
// splits the timestamp into whole days and seconds of the day
// ----------------------------------------------------------------------------
module etud_day_split (
  input  logic                                clk,
  input  logic [etud_pkg::SPLIT_STAGES-1:0]   load,
  input  logic [etud_pkg::SECS_W-1:0]         epoch_seconds,
  output etud_pkg::etud_split_t               split
);

  localparam int PRE_W  = etud_pkg::SECS_W - etud_pkg::DAY_PRE;
  localparam int PROD_W = PRE_W + etud_pkg::DAY_MUL_W;
  localparam int DSEC_W = etud_pkg::DAYS_W + etud_pkg::REM_W;

  logic [PROD_W-1:0]            day_prod;
  logic [etud_pkg::SECS_W-1:0]  secs;
  logic [etud_pkg::DAYS_W-1:0]  days;
  logic [DSEC_W-1:0]            day_secs;
  logic [etud_pkg::SECS_W-1:0]  rem_full;

  assign day_prod = PROD_W'(epoch_seconds[etud_pkg::SECS_W-1:etud_pkg::DAY_PRE])
                    * PROD_W'(etud_pkg::DAY_MUL);

  // stage 1: day count by reciprocal multiply
  always_ff @(posedge clk) begin
    if (load[0]) begin
      secs <= epoch_seconds;
      days <= day_prod[etud_pkg::DAY_SHIFT +: etud_pkg::DAYS_W];
    end
  end

  assign day_secs = DSEC_W'(days) * DSEC_W'(etud_pkg::SECS_PER_DAY);
  assign rem_full = secs - day_secs[etud_pkg::SECS_W-1:0];

  // stage 2: seconds left within the day
  always_ff @(posedge clk) begin
    if (load[1]) begin
      split.days <= days;
      split.rem  <= rem_full[etud_pkg::REM_W-1:0];
    end
  end

endmodule

@@ src/etud_clock_path.sv @@
// ----------------------------------------------------------------------------
// etud_clock_path
// hour, minute, second and weekday from the day split
// ----------------------------------------------------------------------------
module etud_clock_path (
  input  logic                                clk,
  input  logic [etud_pkg::PATH_STAGES-1:0]    load,
  input  etud_pkg::etud_split_t               split,
  output etud_pkg::etud_clock_t               clock
);

  localparam int HX_W   = etud_pkg::REM_W - etud_pkg::HOUR_PRE;
  localparam int HP_W   = HX_W + etud_pkg::HOUR_MUL_W;
  localparam int WP_W   = etud_pkg::DAYS_W + etud_pkg::WDAY_MUL_W;
  localparam int REM2_W = 12;
  localparam int MX_W   = REM2_W - etud_pkg::MIN_PRE;
  localparam int MP_W   = MX_W + etud_pkg::MIN_MUL_W;

  // stage 3
  logic [HP_W-1:0]                hour_prod;
  logic [etud_pkg::DAYS_W-1:0]    wv_next;
  logic [WP_W-1:0]                wday_prod;
  logic [etud_pkg::REM_W-1:0]     rem3;
  logic [etud_pkg::HOUR_W-1:0]    hour3;
  logic [etud_pkg::DAYS_W-1:0]    wv3;
  logic [etud_pkg::WQ_W-1:0]      wq3;
  // stage 4
  logic [etud_pkg::REM_W-1:0]     hour_secs;
  logic [etud_pkg::REM_W-1:0]     rem2_full;
  logic [etud_pkg::DAYS_W-1:0]    wq_days;
  logic [etud_pkg::DAYS_W-1:0]    wday_full;
  logic [REM2_W-1:0]              rem4;
  logic [etud_pkg::HOUR_W-1:0]    hour4;
  logic [etud_pkg::WDAY_W-1:0]    wday4;
  // stage 5
  logic [MP_W-1:0]                min_prod;
  logic [REM2_W-1:0]              rem5;
  logic [etud_pkg::MIN_W-1:0]     min5;
  logic [etud_pkg::HOUR_W-1:0]    hour5;
  logic [etud_pkg::WDAY_W-1:0]    wday5;
  // stage 6 and the delay to the output stage
  logic [REM2_W-1:0]              min_secs;
  logic [REM2_W-1:0]              sec_full;
  etud_pkg::etud_clock_t          clock6;
  etud_pkg::etud_clock_t          clock7;

  assign hour_prod = HP_W'(split.rem[etud_pkg::REM_W-1:etud_pkg::HOUR_PRE])
                     * HP_W'(etud_pkg::HOUR_MUL);
  assign wv_next   = split.days + etud_pkg::DAYS_W'(etud_pkg::EPOCH_WEEKDAY);
  assign wday_prod = WP_W'(wv_next) * WP_W'(etud_pkg::WDAY_MUL);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      rem3  <= split.rem;
      hour3 <= hour_prod[etud_pkg::HOUR_SHIFT +: etud_pkg::HOUR_W];
      wv3   <= wv_next;
      wq3   <= wday_prod[etud_pkg::WDAY_SHIFT +: etud_pkg::WQ_W];
    end
  end

  assign hour_secs = etud_pkg::REM_W'(hour3) * etud_pkg::REM_W'(etud_pkg::SECS_PER_HOUR);
  assign rem2_full = rem3 - hour_secs;
  assign wq_days   = etud_pkg::DAYS_W'(wq3) * etud_pkg::DAYS_W'(etud_pkg::DAYS_PER_WEEK);
  assign wday_full = wv3 - wq_days;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      rem4  <= rem2_full[REM2_W-1:0];
      hour4 <= hour3;
      wday4 <= wday_full[etud_pkg::WDAY_W-1:0];
    end
  end

  assign min_prod = MP_W'(rem4[REM2_W-1:etud_pkg::MIN_PRE]) * MP_W'(etud_pkg::MIN_MUL);

  always_ff @(posedge clk) begin
    if (load[2]) begin
      rem5  <= rem4;
      min5  <= min_prod[etud_pkg::MIN_SHIFT +: etud_pkg::MIN_W];
      hour5 <= hour4;
      wday5 <= wday4;
    end
  end

  assign min_secs = REM2_W'(min5) * REM2_W'(etud_pkg::SECS_PER_MIN);
  assign sec_full = rem5 - min_secs;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      clock6.second_of_minute <= sec_full[etud_pkg::SEC_W-1:0];
      clock6.minute_of_hour   <= min5;
      clock6.hour_of_day      <= hour5;
      clock6.weekday          <= wday5;
    end
  end

  // clock fields are done early; ride along with the date path
  always_ff @(posedge clk) begin
    if (load[4]) begin
      clock7 <= clock6;
    end
    if (load[5]) begin
      clock <= clock7;
    end
  end

endmodule

@@ src/etud_date_path.sv @@
// ----------------------------------------------------------------------------
// etud_date_path
// gregorian year, month and day of month from the day count
// ----------------------------------------------------------------------------
module etud_date_path (
  input  logic                                clk,
  input  logic [etud_pkg::PATH_STAGES-1:0]    load,
  input  logic [etud_pkg::DAYS_W-1:0]         days,
  output etud_pkg::etud_date_t                date
);

  localparam int DNUM_W = etud_pkg::DNUM_W;
  localparam int YEAR_W = etud_pkg::YEAR_W;
  localparam int YDAY_W = etud_pkg::YDAY_W;
  localparam int MON_W  = etud_pkg::MON_W;
  localparam int YP_W   = DNUM_W + etud_pkg::YEAR_MUL_W;
  localparam int C1X_W  = YEAR_W - 2;
  localparam int C4X_W  = YEAR_W - 4;
  localparam int C1P_W  = C1X_W + etud_pkg::CENT_MUL_W;
  localparam int C4P_W  = C4X_W + etud_pkg::CENT_MUL_W;
  localparam int BASE_W = DNUM_W + 1;
  localparam int DIFF_W = BASE_W + 1;
  localparam int MP_W   = YDAY_W + etud_pkg::MON_MUL_W;

  // stage 3
  logic [DNUM_W-1:0]                dnum_next;
  logic [DNUM_W-1:0]                est_next;
  logic [YP_W-1:0]                  year_prod;
  logic [DNUM_W-1:0]                d3;
  logic [YEAR_W-1:0]                year3;
  // stage 4
  logic [C1P_W-1:0]                 q100_prod;
  logic [C4P_W-1:0]                 q400_prod;
  logic [BASE_W-1:0]                y365_next;
  logic [DNUM_W-1:0]                d4;
  logic [YEAR_W-1:0]                year4;
  logic [etud_pkg::Q100_W-1:0]      q100_4;
  logic [etud_pkg::Q400_W-1:0]      q400_4;
  logic [BASE_W-1:0]                y365_4;
  // stage 5
  logic [BASE_W-1:0]                base_next;
  logic [YEAR_W-1:0]                cent_years;
  logic [YEAR_W-1:0]                era_years;
  logic                             leap_next;
  logic [DNUM_W-1:0]                d5;
  logic [YEAR_W-1:0]                year5;
  logic [BASE_W-1:0]                base5;
  logic                             leap5;
  // stage 6
  logic signed [DIFF_W-1:0]         diff;
  logic [YDAY_W-1:0]                yday_next;
  logic [YEAR_W-1:0]                year_next;
  logic [YDAY_W-1:0]                yday6;
  logic [YEAR_W-1:0]                year6;
  // stage 7
  logic [YDAY_W-1:0]                mx;
  logic [MP_W-1:0]                  mon_prod;
  logic [YDAY_W-1:0]                yday7;
  logic [YEAR_W-1:0]                year7;
  logic [MON_W-1:0]                 mon7;
  // stage 8
  logic [YDAY_W-1:0]                mday_full;

  assign dnum_next = DNUM_W'(days) + DNUM_W'(etud_pkg::DAY_BASE);
  assign est_next  = DNUM_W'(days) + DNUM_W'(etud_pkg::DAY_BASE + 2);
  assign year_prod = YP_W'(est_next) * YP_W'(etud_pkg::YEAR_MUL);

  // first guess of the march-based year, may be one too high
  always_ff @(posedge clk) begin
    if (load[0]) begin
      d3    <= dnum_next;
      year3 <= year_prod[etud_pkg::YEAR_SHIFT +: YEAR_W];
    end
  end

  assign q100_prod = C1P_W'(year3[YEAR_W-1:2]) * C1P_W'(etud_pkg::CENT_MUL);
  assign q400_prod = C4P_W'(year3[YEAR_W-1:4]) * C4P_W'(etud_pkg::CENT_MUL);
  assign y365_next = BASE_W'(year3) * BASE_W'(etud_pkg::YEAR_DAYS);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      d4     <= d3;
      year4  <= year3;
      q100_4 <= q100_prod[etud_pkg::CENT_SHIFT +: etud_pkg::Q100_W];
      q400_4 <= q400_prod[etud_pkg::CENT_SHIFT +: etud_pkg::Q400_W];
      y365_4 <= y365_next;
    end
  end

  // days before 1 march of the guessed year, and its leap flag
  assign base_next  = y365_4 + BASE_W'(year4[YEAR_W-1:2]) - BASE_W'(q100_4)
                      + BASE_W'(q400_4);
  assign cent_years = YEAR_W'(q100_4) * YEAR_W'(100);
  assign era_years  = YEAR_W'(q400_4) * YEAR_W'(400);
  assign leap_next  = (year4[1:0] == 2'b00) &&
                      ((year4 != cent_years) || (year4 == era_years));

  always_ff @(posedge clk) begin
    if (load[2]) begin
      d5    <= d4;
      year5 <= year4;
      base5 <= base_next;
      leap5 <= leap_next;
    end
  end

  // overshoot into the next year: step back and add that year's length
  assign diff = $signed(DIFF_W'(d5)) - $signed(DIFF_W'(base5));

  always_comb begin
    if (diff[DIFF_W-1]) begin
      yday_next = diff[YDAY_W-1:0] + YDAY_W'(etud_pkg::YEAR_DAYS) + YDAY_W'(leap5);
      year_next = year5 - YEAR_W'(1);
    end else begin
      yday_next = diff[YDAY_W-1:0];
      year_next = year5;
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      yday6 <= yday_next;
      year6 <= year_next;
    end
  end

  assign mx       = yday6 + YDAY_W'(31);
  assign mon_prod = MP_W'(mx) * MP_W'(etud_pkg::MON_MUL);

  always_ff @(posedge clk) begin
    if (load[4]) begin
      yday7 <= yday6;
      year7 <= year6;
      mon7  <= mon_prod[etud_pkg::MON_SHIFT +: MON_W];
    end
  end

  // back from march-based to january-based months
  assign mday_full = yday7 - etud_pkg::month_start(mon7) + YDAY_W'(1);

  always_ff @(posedge clk) begin
    if (load[5]) begin
      date.day_of_month <= mday_full[etud_pkg::MDAY_W-1:0];
      if (yday7 >= YDAY_W'(etud_pkg::MARCH_YDAY_OF_JAN)) begin
        date.month_number <= mon7 - MON_W'(10);
        date.full_year    <= year7 + YEAR_W'(1);
      end else begin
        date.month_number <= mon7 + MON_W'(2);
        date.full_year    <= year7;
      end
    end
  end

endmodule

@@ src/epoch_seconds_to_utc_date.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date
// unix time to utc calendar date and time of day
// ----------------------------------------------------------------------------
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into second, minute, hour, day of month, month (1-12), full year and
// weekday (0 = Sunday). Every input value is legal; the last one, 0xFFFFFFFF,
// maps to Sunday 2106-02-07 06:28:15. The converter is a fully pipelined,
// stateless datapath of eight register stages: it accepts one timestamp per
// clock while the output side is not stalled. Each result moves through the
// stages to the output register and waits there until it is taken.
// The eight-stage depth comes from the chain of
// reciprocal multiplies (seconds to days, day number to year, day of year to
// month), each followed by its own register. The last stage is the output
// register; each stage refills as soon as its content moves on, so bubbles
// close up under back-pressure and nothing is dropped or repeated. Reset
// clears only the valid bits.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_date (
  input  logic        clk,
  input  logic        rst,
  etud_in_if.sink     stamp,
  etud_out_if.source  calendar
);

  // per-stage load enables, stage 0 takes the incoming request
  logic [etud_pkg::STAGES-1:0]  load;

  // day count and seconds of the day after the first two stages
  etud_pkg::etud_split_t        split;

  // results of the two parallel paths, both held in the output stage
  etud_pkg::etud_clock_t        clock;
  etud_pkg::etud_date_t         date;

  // valid tracking and back-pressure for all stages
  etud_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stamp.valid),
    .in_ready  (stamp.ready),
    .out_valid (calendar.valid),
    .out_ready (calendar.ready),
    .load      (load)
  );

  // seconds to days and seconds within the day
  etud_day_split u_split (
    .clk           (clk),
    .load          (load[etud_pkg::SPLIT_STAGES-1:0]),
    .epoch_seconds (stamp.epoch_seconds),
    .split         (split)
  );

  // time of day and weekday
  etud_clock_path u_clock (
    .clk   (clk),
    .load  (load[etud_pkg::STAGES-1:etud_pkg::SPLIT_STAGES]),
    .split (split),
    .clock (clock)
  );

  // gregorian date from the day count
  etud_date_path u_date (
    .clk  (clk),
    .load (load[etud_pkg::STAGES-1:etud_pkg::SPLIT_STAGES]),
    .days (split.days),
    .date (date)
  );

  // output request fields
  assign calendar.second_of_minute = clock.second_of_minute;
  assign calendar.minute_of_hour   = clock.minute_of_hour;
  assign calendar.hour_of_day      = clock.hour_of_day;
  assign calendar.weekday          = clock.weekday;
  assign calendar.day_of_month     = date.day_of_month;
  assign calendar.month_number     = date.month_number;
  assign calendar.full_year        = date.full_year;

endmodule
